### hdl/pnsb_pkg.sv
package pnsb_pkg;

   // Input item modes
   typedef enum logic [1:0] {
      MODE_WR_SRC = 2'd0,
      MODE_WR_DST = 2'd1,
      MODE_RD_DST = 2'd2,
      MODE_BLIT   = 2'd3
   } mode_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_OFFSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_PITCH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_COLS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ROWS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_PITCH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_COLS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_ROWS   = 3'd7;

   localparam int REG_W = 16;

   // Result status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam int CNT_W      = 14;
   localparam int CHK_W      = 34;
   localparam int PROD_W     = 2 * REG_W;
   localparam int DIV_W      = REG_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] byte_addr;
      logic [7:0]  wr_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0]       rd_byte;
      logic             status;
      logic [CNT_W-1:0] pixels_done;
   } rsp_item_type;

   typedef struct packed {
      logic [REG_W-1:0] src_offset;
      logic [REG_W-1:0] src_pitch;
      logic [REG_W-1:0] src_cols;
      logic [REG_W-1:0] src_rows;
      logic [REG_W-1:0] dst_offset;
      logic [REG_W-1:0] dst_pitch;
      logic [REG_W-1:0] dst_cols;
      logic [REG_W-1:0] dst_rows;
   } cfg_type;

   // Classified command handed from the front queue to the engine
   typedef struct packed {
      mode_type    op;
      logic        in_range;
      logic [11:0] byte_addr;
      logic [7:0]  wr_byte;
   } cmd_type;

endpackage

### hdl/packed_nibble_stretch_blitter_unit.sv
// Packed 4-bit stretch blitter. Two byte stores (SRC_BYTES and DST_BYTES deep) hold
// surfaces of packed nibble pixels, even pixel in the high nibble. Each item gives
// exactly one result. Mode 0/1 write a source/destination byte (ignored beyond the
// store); mode 2 reads a destination byte through a registered memory read (zero
// beyond the store). Mode 3 runs a blit: a rectangle check of both surfaces (multiply,
// sum and end-check states; rejects with status 1 and copies nothing), two 16-step
// serial divides for the scale factors, then per destination row a multiply and an
// add state plus a nibble read-modify-write per pixel (read state, then write state)
// on the destination memory port; pixels_done is the pixel count modulo 2^14.
// A two-entry command queue sits in front of the engine and the result sits in its
// own register, so items can be pushed while a result waits to be popped.
// Configuration registers (index 0..7: src offset, pitch, cols, rows, then the same
// for the destination) must only be written while the block is idle; csr_ready is
// always high. Store contents after reset are undefined until written.
module packed_nibble_stretch_blitter_unit
   import pnsb_pkg::*;
#(
   parameter int SRC_BYTES = 4096,
   parameter int DST_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  req_item_type         req_data,
   output logic                 empty,
   input  logic                 pop,
   output rsp_item_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // Config writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_OFFSET: cfg_in.src_offset = csr_wdata;
            CSR_SRC_PITCH:  cfg_in.src_pitch  = csr_wdata;
            CSR_SRC_COLS:   cfg_in.src_cols   = csr_wdata;
            CSR_SRC_ROWS:   cfg_in.src_rows   = csr_wdata;
            CSR_DST_OFFSET: cfg_in.dst_offset = csr_wdata;
            CSR_DST_PITCH:  cfg_in.dst_pitch  = csr_wdata;
            CSR_DST_COLS:   cfg_in.dst_cols   = csr_wdata;
            CSR_DST_ROWS:   cfg_in.dst_rows   = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: decode the item and hold it in the command queue
   pnsb_front #(
      .SRC_BYTES (SRC_BYTES),
      .DST_BYTES (DST_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   // Back: stores, rectangle check, scaling walk and the result register
   pnsb_engine #(
      .SRC_BYTES (SRC_BYTES),
      .DST_BYTES (DST_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/pnsb_front.sv
module pnsb_front
   import pnsb_pkg::*;
#(
   parameter int SRC_BYTES = 4096,
   parameter int DST_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_data,
   output logic         cmd_valid,
   input  logic         cmd_pop,
   output cmd_type      cmd
);

   cmd_type                q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   cmd_type                cls;
   logic                   do_push;
   logic                   do_pop;

   // Classify: decode mode and check the byte address against its store
   always_comb begin
      cls.op        = mode_type'(req_data.mode);
      cls.byte_addr = req_data.byte_addr;
      cls.wr_byte   = req_data.wr_byte;
      unique case (cls.op)
         MODE_WR_SRC: cls.in_range = (32'(req_data.byte_addr) < 32'(SRC_BYTES));
         MODE_WR_DST, MODE_RD_DST:
            cls.in_range = (32'(req_data.byte_addr) < 32'(DST_BYTES));
         default:     cls.in_range = 1'b0;
      endcase
   end

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### hdl/pnsb_div.sv
module pnsb_div
   import pnsb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W:0]       trial;
   logic                 ge;

   // One restoring step: shift in the next numerator bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hdl/pnsb_engine.sv
module pnsb_engine
   import pnsb_pkg::*;
#(
   parameter int SRC_BYTES = 4096,
   parameter int DST_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cmd_valid,
   output logic         cmd_pop,
   input  cmd_type      cmd,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_data
);

   localparam int SAW = (SRC_BYTES > 1) ? $clog2(SRC_BYTES) : 1;
   localparam int DAW = (DST_BYTES > 1) ? $clog2(DST_BYTES) : 1;
   localparam int SPW = SAW + 1;
   localparam int DPW = DAW + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_CHK_MUL,
      ST_CHK_SUM,
      ST_CHK_END,
      ST_DIV_X,
      ST_DIV_Y,
      ST_ROW_MUL,
      ST_ROW_ADD,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;
   logic             rsp_load;
   logic             rd_ok_ff, rd_ok_in;
   logic [PROD_W-1:0] prod_s_ff, prod_s_in;
   logic [PROD_W-1:0] prod_d_ff, prod_d_in;
   logic             fit_s_ff, fit_s_in;
   logic             fit_d_ff, fit_d_in;
   logic [REG_W-1:0] qx_ff, qx_in, remx_ff, remx_in;
   logic [REG_W-1:0] qy_ff, qy_in, remy_ff, remy_in;
   logic [REG_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [REG_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [REG_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [SPW-1:0]   src_base_ff, src_base_in;
   logic [DPW-1:0]   dst_base_ff, dst_base_in;
   logic             s_lo_ff, s_lo_in;
   logic             d_lo_ff, d_lo_in;
   logic [DAW-1:0]   d_byte_ff, d_byte_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             out_free;
   logic [REG_W-1:0] src_rows_m1, dst_rows_m1;
   logic [CHK_W-1:0] last_s, last_d;
   logic [SPW-1:0]   sp;
   logic [DPW-1:0]   dp;
   logic [3:0]       nib;
   logic [7:0]       merged;
   logic [REG_W:0]   rx_sum, ry_sum;
   logic             xc, yc;
   logic [REG_W-1:0] rx_adv, ry_adv, sx_adv, sy_adv;

   logic             div_start, div_done;
   logic [DIV_W-1:0] div_num, div_den, div_quo, div_rem;

   logic [7:0]       src_mem [SRC_BYTES];
   logic [7:0]       dst_mem [DST_BYTES];
   logic             src_we, src_re, dst_we, dst_re;
   logic [SAW-1:0]   src_waddr, src_raddr;
   logic [DAW-1:0]   dst_waddr, dst_raddr;
   logic [7:0]       src_wdata, dst_wdata;
   logic [7:0]       src_rdata_ff, dst_rdata_ff;

   pnsb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .num       (div_num),
      .den       (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign out_free = !rsp_valid_ff || pop;

   // Rectangle check terms
   assign src_rows_m1 = cfg.src_rows - 1'b1;
   assign dst_rows_m1 = cfg.dst_rows - 1'b1;
   assign last_s = CHK_W'(cfg.src_offset) + CHK_W'(prod_s_ff) + CHK_W'(cfg.src_cols)
                   - CHK_W'(1);
   assign last_d = CHK_W'(cfg.dst_offset) + CHK_W'(prod_d_ff) + CHK_W'(cfg.dst_cols)
                   - CHK_W'(1);

   // Pixel addresses and nibble merge
   assign sp     = src_base_ff + SPW'(sx_ff);
   assign dp     = dst_base_ff + DPW'(dx_ff);
   assign nib    = s_lo_ff ? src_rdata_ff[3:0] : src_rdata_ff[7:4];
   assign merged = d_lo_ff ? {dst_rdata_ff[7:4], nib} : {nib, dst_rdata_ff[3:0]};

   // Stepping of the scaled source coordinates: quotient plus carried remainder
   assign rx_sum = {1'b0, rx_ff} + {1'b0, remx_ff};
   assign xc     = (rx_sum >= {1'b0, cfg.dst_cols});
   assign rx_adv = xc ? REG_W'(rx_sum - {1'b0, cfg.dst_cols}) : rx_sum[REG_W-1:0];
   assign sx_adv = sx_ff + qx_ff + REG_W'(xc);
   assign ry_sum = {1'b0, ry_ff} + {1'b0, remy_ff};
   assign yc     = (ry_sum >= {1'b0, cfg.dst_rows});
   assign ry_adv = yc ? REG_W'(ry_sum - {1'b0, cfg.dst_rows}) : ry_sum[REG_W-1:0];
   assign sy_adv = sy_ff + qy_ff + REG_W'(yc);

   always_comb begin
      state_in    = state_ff;
      rsp_in      = rsp_ff;
      rsp_load    = 1'b0;
      rd_ok_in    = rd_ok_ff;
      prod_s_in   = prod_s_ff;
      prod_d_in   = prod_d_ff;
      fit_s_in    = fit_s_ff;
      fit_d_in    = fit_d_ff;
      qx_in       = qx_ff;
      remx_in     = remx_ff;
      qy_in       = qy_ff;
      remy_in     = remy_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      src_base_in = src_base_ff;
      dst_base_in = dst_base_ff;
      s_lo_in     = s_lo_ff;
      d_lo_in     = d_lo_ff;
      d_byte_in   = d_byte_ff;
      count_in    = count_ff;
      cmd_pop     = 1'b0;
      src_we      = 1'b0;
      src_re      = 1'b0;
      dst_we      = 1'b0;
      dst_re      = 1'b0;
      src_waddr   = SAW'(cmd.byte_addr);
      src_raddr   = sp[SPW-1:1];
      src_wdata   = cmd.wr_byte;
      dst_waddr   = DAW'(cmd.byte_addr);
      dst_raddr   = DAW'(cmd.byte_addr);
      dst_wdata   = cmd.wr_byte;
      div_start   = 1'b0;
      div_num     = cfg.src_cols;
      div_den     = cfg.dst_cols;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  MODE_WR_SRC, MODE_WR_DST: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        src_we   = (cmd.op == MODE_WR_SRC) && cmd.in_range;
                        dst_we   = (cmd.op == MODE_WR_DST) && cmd.in_range;
                        rsp_load = 1'b1;
                        rsp_in   = '{rd_byte: '0, status: STATUS_OK, pixels_done: '0};
                     end
                  end
                  MODE_RD_DST: begin
                     cmd_pop  = 1'b1;
                     dst_re   = cmd.in_range;
                     rd_ok_in = cmd.in_range;
                     state_in = ST_RD_WAIT;
                  end
                  default: begin
                     cmd_pop  = 1'b1;
                     state_in = ST_CHK_MUL;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{rd_byte: rd_ok_ff ? dst_rdata_ff : 8'd0,
                            status: STATUS_OK, pixels_done: '0};
               state_in = ST_IDLE;
            end
         end
         ST_CHK_MUL: begin
            prod_s_in = src_rows_m1 * cfg.src_pitch;
            prod_d_in = dst_rows_m1 * cfg.dst_pitch;
            state_in  = ST_CHK_SUM;
         end
         ST_CHK_SUM: begin
            fit_s_in = (cfg.src_cols != '0) && (cfg.src_rows != '0) &&
                       (cfg.src_pitch != '0) && (cfg.src_cols <= cfg.src_pitch) &&
                       ((last_s >> 1) < CHK_W'(SRC_BYTES));
            fit_d_in = (cfg.dst_cols != '0) && (cfg.dst_rows != '0) &&
                       (cfg.dst_pitch != '0) && (cfg.dst_cols <= cfg.dst_pitch) &&
                       ((last_d >> 1) < CHK_W'(DST_BYTES));
            state_in = ST_CHK_END;
         end
         ST_CHK_END: begin
            if (!(fit_s_ff && fit_d_ff)) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  rsp_in   = '{rd_byte: '0, status: STATUS_REJECT, pixels_done: '0};
                  state_in = ST_IDLE;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               qx_in     = div_quo;
               remx_in   = div_rem;
               div_start = 1'b1;
               div_num   = cfg.src_rows;
               div_den   = cfg.dst_rows;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               qy_in    = div_quo;
               remy_in  = div_rem;
               dy_in    = '0;
               sy_in    = '0;
               ry_in    = '0;
               count_in = '0;
               state_in = ST_ROW_MUL;
            end
         end
         ST_ROW_MUL: begin
            prod_s_in = sy_ff * cfg.src_pitch;
            prod_d_in = dy_ff * cfg.dst_pitch;
            dx_in     = '0;
            sx_in     = '0;
            rx_in     = '0;
            state_in  = ST_ROW_ADD;
         end
         ST_ROW_ADD: begin
            src_base_in = SPW'(CHK_W'(cfg.src_offset) + CHK_W'(prod_s_ff));
            dst_base_in = DPW'(CHK_W'(cfg.dst_offset) + CHK_W'(prod_d_ff));
            state_in    = ST_PIX_RD;
         end
         ST_PIX_RD: begin
            src_re    = 1'b1;
            dst_re    = 1'b1;
            dst_raddr = dp[DPW-1:1];
            s_lo_in   = sp[0];
            d_lo_in   = dp[0];
            d_byte_in = dp[DPW-1:1];
            state_in  = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            dst_we    = 1'b1;
            dst_waddr = d_byte_ff;
            dst_wdata = merged;
            count_in  = count_ff + 1'b1;
            if (dx_ff == cfg.dst_cols - 1'b1) begin
               if (dy_ff == dst_rows_m1) begin
                  state_in = ST_FINISH;
               end else begin
                  dy_in    = dy_ff + 1'b1;
                  sy_in    = sy_adv;
                  ry_in    = ry_adv;
                  state_in = ST_ROW_MUL;
               end
            end else begin
               dx_in    = dx_ff + 1'b1;
               sx_in    = sx_adv;
               rx_in    = rx_adv;
               state_in = ST_PIX_RD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{rd_byte: '0, status: STATUS_OK, pixels_done: count_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff      <= rsp_in;
      rd_ok_ff    <= rd_ok_in;
      prod_s_ff   <= prod_s_in;
      prod_d_ff   <= prod_d_in;
      fit_s_ff    <= fit_s_in;
      fit_d_ff    <= fit_d_in;
      qx_ff       <= qx_in;
      remx_ff     <= remx_in;
      qy_ff       <= qy_in;
      remy_ff     <= remy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      src_base_ff <= src_base_in;
      dst_base_ff <= dst_base_in;
      s_lo_ff     <= s_lo_in;
      d_lo_ff     <= d_lo_in;
      d_byte_ff   <= d_byte_in;
      count_ff    <= count_in;
   end

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_waddr] <= src_wdata;
      end
      if (src_re) begin
         src_rdata_ff <= src_mem[src_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dst_we) begin
         dst_mem[dst_waddr] <= dst_wdata;
      end
      if (dst_re) begin
         dst_rdata_ff <= dst_mem[dst_raddr];
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_pix_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PIX_WR |-> $past(state_ff) == ST_PIX_RD)
      else $error("pixel write without preceding read");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || pop))
      else $error("result register overwritten");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_X || state_ff == ST_DIV_Y))
      else $error("divider finished outside a divide state");

endmodule
